@@ hdl/rrbd_pkg.sv @@
package rrbd_pkg;

  localparam int DATA_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int COL_W      = 13;
  localparam int POS_W      = 30;
  localparam int SUM_W      = 22;
  localparam int STEP_W     = 17;
  localparam int BOX_W      = 7;
  localparam int RECIP_W    = 17;
  localparam int CROP_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int MAX_CH     = 3;
  localparam int TDATA_W    = MAX_CH * DATA_W;
  localparam int CHANNELS_DEF = 3;

  localparam logic [STEP_W-1:0] ONE_FX  = STEP_W'(65536);
  localparam logic [FRAC_W-1:0] HALF_FX = FRAC_W'(32768);

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_INTERLEAVED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_START   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_FACTOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_RECIP    = 3'd5;

  // sequencer to lanes
  typedef struct packed {
    logic              acpt;         // pixel taken this cycle
    logic              acpt_hit;     // it makes a sample
    logic              acpt_row_end; // it ends the row
    logic              mul;          // interpolation product stage
    logic              acc;          // box accumulate stage
    logic              avg;          // reciprocal product stage
    logic              fzero;        // sample sits exactly on a pixel
    logic [FRAC_W-1:0] frac;
    logic              row_end;
    logic              box_done;
  } lane_ctl_t;

endpackage

@@ hdl/rrbd_lane.sv @@
module rrbd_lane
  import rrbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lane_ctl_t           ctl_i,
  input  logic [DATA_W-1:0]   cur_i,
  input  logic [RECIP_W-1:0]  recip_i,
  output logic [DATA_W-1:0]   result_o
);

  localparam int PROD_W = 2 * (DATA_W + 1);
  localparam int AVG_W  = SUM_W + RECIP_W;

  logic [DATA_W-1:0] prev_q, pv_q, cur_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0] sum_q, tot_q;
  logic [AVG_W-1:0] avg_q;

  logic signed [DATA_W:0] diff;
  logic signed [PROD_W-1:0] interp;
  logic [DATA_W-1:0] samp;
  logic [SUM_W:0] sum_ext;
  logic [SUM_W-1:0] sum_sat;
  logic [AVG_W:0] rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      sum_q  <= '0;
    end else begin
      if (ctl_i.acpt) begin
        prev_q <= ctl_i.acpt_row_end ? '0 : cur_i;
        if (ctl_i.acpt_row_end && !ctl_i.acpt_hit) begin
          sum_q <= '0;
        end
      end
      if (ctl_i.acc) begin
        sum_q <= (ctl_i.box_done || ctl_i.row_end) ? '0 : sum_sat;
      end
    end
  end

  // prev*(1-f) + cur*f == prev*1 + (cur-prev)*f
  assign diff = $signed({1'b0, cur_q}) - $signed({1'b0, pv_q});
  assign interp = $signed({2'b00, pv_q, {FRAC_W{1'b0}}}) + prod_q
                + $signed(PROD_W'(HALF_FX));
  assign samp = ctl_i.fzero ? cur_q : interp[FRAC_W +: DATA_W];
  assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(samp);
  assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.acpt) begin
      pv_q  <= prev_q;
      cur_q <= cur_i;
    end
    if (ctl_i.mul) begin
      prod_q <= PROD_W'(diff) * PROD_W'($signed({1'b0, ctl_i.frac}));
    end
    if (ctl_i.acc && ctl_i.box_done) begin
      tot_q <= sum_sat;
    end
    if (ctl_i.avg) begin
      avg_q <= AVG_W'(tot_q) * AVG_W'(recip_i);
    end
  end

  assign rnd = {1'b0, avg_q} + (AVG_W+1)'(HALF_FX);
  assign result_o = (|rnd[AVG_W:FRAC_W+DATA_W]) ? {DATA_W{1'b1}}
                                                : rnd[FRAC_W +: DATA_W];

endmodule

@@ hdl/rrbd_ctrl.sv @@
module rrbd_ctrl
  import rrbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_row_end_i,
  output logic                  in_ready_o,
  input  logic                  out_free_i,
  output logic                  out_load_o,
  output logic                  out_last_o,
  output logic                  interleaved_o,
  output logic [RECIP_W-1:0]    recip_o,
  output lane_ctl_t             ctl_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_AVG  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  logic                interleaved_q, interleaved_d;
  logic [CROP_W-1:0]   crop_q, crop_d;
  logic [COL_W-1:0]    count_q, count_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [BOX_W-1:0]    box_q, box_d;
  logic [RECIP_W-1:0]  recip_q, recip_d;

  logic [COL_W-1:0]    col_q, col_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [BOX_W-1:0]    fill_q, fill_d;
  logic [COL_W-1:0]    made_q, made_d;

  logic                fzero_q, row_end_q, done_q, last_q;
  logic [FRAC_W-1:0]   frac_q;

  logic                acpt, hit, fzero, done, last;
  logic [POS_W-FRAC_W-1:0] ip;
  logic [FRAC_W-1:0]   frac;
  logic [STEP_W-1:0]   estep;
  logic [BOX_W-1:0]    ebox, fill_n;
  logic [COL_W-1:0]    made_n, left;
  logic [POS_W:0]      np;

  function automatic logic [POS_W-1:0] start_pos(input logic [STEP_W-1:0] stp,
                                                 input logic [CROP_W-1:0] crp);
    logic [STEP_W-1:0] es;
    es = stp[STEP_W-1] ? stp : ONE_FX;
    return POS_W'(es >> 1) - POS_W'(HALF_FX) + {2'b00, crp, {FRAC_W{1'b0}}};
  endfunction

  always_comb begin
    interleaved_d = interleaved_q;
    crop_d        = crop_q;
    count_d       = count_q;
    step_d        = step_q;
    box_d         = box_q;
    recip_d       = recip_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INTERLEAVED:  interleaved_d = cfg_data_i[0];
        REG_CROP_START:   crop_d  = cfg_data_i[CROP_W-1:0];
        REG_SAMPLE_COUNT: count_d = cfg_data_i[COL_W-1:0];
        REG_STEP_FX:      step_d  = cfg_data_i[STEP_W-1:0];
        REG_BOX_FACTOR:   box_d   = cfg_data_i[BOX_W-1:0];
        REG_BOX_RECIP:    recip_d = cfg_data_i[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign acpt   = in_valid_i && in_ready_o;
  assign ip     = pos_q[POS_W-1:FRAC_W];
  assign frac   = pos_q[FRAC_W-1:0];
  assign fzero  = (frac == '0);
  assign estep  = step_q[STEP_W-1] ? step_q : ONE_FX;
  assign ebox   = (box_q == '0) ? BOX_W'(1) : box_q;
  assign hit    = (made_q < count_q) &&
                  (fzero ? (ip == (POS_W-FRAC_W)'(col_q))
                         : ({1'b0, ip} + 1'b1 == (POS_W-FRAC_W+1)'(col_q)));
  assign fill_n = fill_q + 1'b1;
  assign done   = (fill_n >= ebox);
  assign made_n = made_q + 1'b1;
  assign left   = count_q - made_n;
  assign last   = (left < COL_W'(ebox));
  assign np     = {1'b0, pos_q} + (POS_W+1)'(estep);

  always_comb begin
    col_d  = col_q;
    pos_d  = pos_q;
    fill_d = fill_q;
    made_d = made_q;
    if (acpt) begin
      if (hit) begin
        fill_d = done ? '0 : fill_n;
        made_d = made_n;
        pos_d  = np[POS_W] ? {POS_W{1'b1}} : np[POS_W-1:0];
      end
      if (col_q != {COL_W{1'b1}}) begin
        col_d = col_q + 1'b1;
      end
      if (in_row_end_i) begin
        col_d  = '0;
        fill_d = '0;
        made_d = '0;
        pos_d  = start_pos(step_d, crop_d);
      end
    end else if (cfg_we_i && col_q == '0 &&
                 (cfg_idx_i == REG_CROP_START || cfg_idx_i == REG_STEP_FX)) begin
      pos_d = start_pos(step_d, crop_d);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (acpt && hit) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = done_q ? ST_AVG : ST_IDLE;
      ST_AVG:  state_d = ST_FIN;
      ST_FIN:  if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      interleaved_q <= 1'b1;
      crop_q        <= '0;
      count_q       <= COL_W'(1);
      step_q        <= ONE_FX;
      box_q         <= BOX_W'(1);
      recip_q       <= ONE_FX;
      col_q         <= '0;
      pos_q         <= start_pos(ONE_FX, '0);
      fill_q        <= '0;
      made_q        <= '0;
    end else begin
      state_q       <= state_d;
      interleaved_q <= interleaved_d;
      crop_q        <= crop_d;
      count_q       <= count_d;
      step_q        <= step_d;
      box_q         <= box_d;
      recip_q       <= recip_d;
      col_q         <= col_d;
      pos_q         <= pos_d;
      fill_q        <= fill_d;
      made_q        <= made_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acpt) begin
      fzero_q   <= fzero;
      frac_q    <= frac;
      row_end_q <= in_row_end_i;
      done_q    <= done;
      last_q    <= last;
    end
  end

  assign out_load_o    = (state_q == ST_FIN) && out_free_i;
  assign out_last_o    = last_q;
  assign interleaved_o = interleaved_q;
  assign recip_o       = recip_q;

  assign ctl_o.acpt         = acpt;
  assign ctl_o.acpt_hit     = hit;
  assign ctl_o.acpt_row_end = in_row_end_i;
  assign ctl_o.mul          = (state_q == ST_MUL);
  assign ctl_o.acc          = (state_q == ST_ACC);
  assign ctl_o.avg          = (state_q == ST_AVG);
  assign ctl_o.fzero        = fzero_q;
  assign ctl_o.frac         = frac_q;
  assign ctl_o.row_end      = row_end_q;
  assign ctl_o.box_done     = done_q;

endmodule

@@ hdl/rgb_row_bilinear_box_downscaler_core.sv @@
// Row downscaler: each input word is one pixel of a row (red, green, blue, or one sample
// in red when interleaving is off); bilinear samples at (j+0.5)*step-0.5+crop_start are
// summed in runs of box_factor and scaled by box_recip into one output word, tlast marking
// the last full box of the row. Pixels are taken one at a time, the next only once the last
// is through. A pixel that yields no sample needs no sequencer step; for one that yields a
// sample the sequencer steps each lane through the interpolation product and the
// accumulate, and for one that closes a box also through the reciprocal product, one
// register stage each, and then waits until the output register is free. Write
// configuration only between rows or while no pixel is in work.
module rgb_row_bilinear_box_downscaler_core
  import rrbd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,  // pix_r, pix_g, pix_b
  input  logic                  s_axis_tlast,  // row_end
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,  // out_r, out_g, out_b
  output logic                  m_axis_tlast   // row_last
);

  lane_ctl_t          ctl;
  logic               out_free, out_load, out_last, interleaved;
  logic [RECIP_W-1:0] recip;
  logic [DATA_W-1:0]  lane_res [MAX_CH];

  logic               valid_q;
  logic [TDATA_W-1:0] data_q;
  logic               last_q;
  logic [TDATA_W-1:0] data_d;

  assign out_free = !valid_q || m_axis_tready;

  rrbd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i    (s_axis_tvalid),
    .in_row_end_i  (s_axis_tlast),
    .in_ready_o    (s_axis_tready),
    .out_free_i    (out_free),
    .out_load_o    (out_load),
    .out_last_o    (out_last),
    .interleaved_o (interleaved),
    .recip_o       (recip),
    .ctl_o         (ctl)
  );

  for (genvar c = 0; c < MAX_CH; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      logic [DATA_W-1:0] cur;
      assign cur = (c == 0 || interleaved) ? s_axis_tdata[c*DATA_W +: DATA_W] : '0;
      rrbd_lane u_lane (
        .clk_i,
        .rst_ni,
        .ctl_i    (ctl),
        .cur_i    (cur),
        .recip_i  (recip),
        .result_o (lane_res[c])
      );
    end else begin : g_off
      assign lane_res[c] = '0;
    end
  end

  // merge: green and blue read as zero in single-channel mode
  always_comb begin
    for (int c = 0; c < MAX_CH; c++) begin
      data_d[c*DATA_W +: DATA_W] = (c == 0 || interleaved) ? lane_res[c] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_load) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      data_q <= data_d;
      last_q <= out_last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

endmodule

@@ hdl/rrbd_chk.sv @@
module rrbd_chk
  import rrbd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tlast
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // a new word only comes out of the final step of a busy pixel
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output word appeared without a pixel in work");

  // a pixel taken cannot produce its word in the very next cycle
  a_no_instant_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("output word came too early after a pixel");

endmodule

bind rgb_row_bilinear_box_downscaler_core rrbd_chk u_rrbd_chk (.*);
